@@ rtl/rgbhst_pkg.sv @@
// Package for the RGB565 horizontal scaler with column-major output.
// Holds widths, limits and configuration register indexes; no dependencies.
`default_nettype none

package rgbhst_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_COLUMNS = 1023;
    localparam int MAX_ROWS    = 510;

    localparam int PIX_W   = 16;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int PAIR_W  = 8;
    localparam int PITCH_W = 10;
    localparam int ADDR_W  = 20;
    localparam int PHASE_W = 27;
    localparam int PINT_W  = PHASE_W - FRAC_BITS;

    // Divider for the phase step: (source_width << FRAC_BITS) / dest_width
    localparam int NUM_W   = COL_W + FRAC_BITS;
    localparam int DCNT_W  = $clog2(NUM_W + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_DEST_WIDTH   = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_SOURCE_WIDTH = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_SOURCE_PITCH = t_cfg_idx'(3);

endpackage

`default_nettype wire

@@ rtl/rgb565_hscale_transpose.sv @@
// Top level of the RGB565 horizontal linear-interpolation scaler.
// Depends on rgbhst_pkg for widths, limits and register indexes.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | in        | i_in_valid / o_in_ready    | i_left_pixel, i_right_pixel
//  out     | out       | o_out_valid / i_out_ready  | o_pixel_out, o_dest_column, o_dest_row,
//          |           |                            | o_next_fetch_address, o_frame_last
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One pixel pair per cycle while neither the divider nor a stalled output holds the input:
// blend, counter update and next address are worked out in the cycle of the transfer and
// land in the output register. The phase step comes from a one-bit-per-step restoring
// divider that reruns after reset and after each register write; while it runs no pixel pair is taken.
// A stalled output holds the output register and stops the input side in the same cycle.
`default_nettype none

module rgb565_hscale_transpose
    import rgbhst_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,

    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [PIX_W-1:0]          i_left_pixel,
    input  wire logic [PIX_W-1:0]          i_right_pixel,

    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [PIX_W-1:0]               o_pixel_out,
    output logic [COL_W-1:0]               o_dest_column,
    output logic [ROW_W-1:0]               o_dest_row,
    output logic [ADDR_W-1:0]              o_next_fetch_address,
    output logic                           o_frame_last,

    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic [COL_W-1:0]   r_dest_width;
    logic [COL_W-1:0]   r_source_width;
    logic [ROW_W-1:0]   r_image_height;
    logic [PITCH_W-1:0] r_source_pitch;

    // Scan state
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [PHASE_W-1:0] r_phase_step;
    logic [COL_W-1:0]   r_col, n_col;
    logic [PAIR_W-1:0]  r_pair, n_pair;
    logic               r_even, n_even;

    // Divider
    logic               r_div_load;
    logic               r_div_busy;
    logic [DCNT_W-1:0]  r_div_cnt;
    logic [NUM_W-1:0]   r_div_q;
    logic [COL_W-1:0]   r_div_rem;
    logic [COL_W-1:0]   r_div_den;
    logic [COL_W:0]     div_sh;
    logic               div_bit;

    // Output register
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_pix;
    logic [COL_W-1:0]   r_ocol;
    logic [ROW_W-1:0]   r_orow;
    logic [ADDR_W-1:0]  r_oaddr;
    logic               r_olast;

    logic               cfg_xfer;
    logic               in_xfer;
    logic               div_idle;

    logic [COL_W-1:0]   eff_width;
    logic [ROW_W-1:0]   h_clamp;
    logic [PAIR_W-1:0]  pairs_raw;
    logic [PAIR_W-1:0]  eff_pairs;

    logic               frame_start;
    logic [PHASE_W-1:0] step_use;
    logic [FRAC_BITS-1:0] w1;
    logic [FRAC_BITS:0]   w0;
    logic [FRAC_BITS+5:0] s_red, s_blue;
    logic [FRAC_BITS+6:0] s_green;
    logic [PIX_W-1:0]   pix;
    logic [ROW_W-1:0]   cur_row;
    logic [ROW_W-1:0]   nxt_row;
    logic               last_col, last_pair, frame_last;
    logic [ADDR_W-1:0]  addr;

    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid & o_cfg_ready;
    assign div_idle    = ~r_div_load & ~r_div_busy;
    assign o_in_ready  = div_idle & (~r_out_valid | i_out_ready);
    assign in_xfer     = i_in_valid & o_in_ready;

    // Effective geometry
    always_comb begin
        eff_width = (r_dest_width == '0) ? COL_W'(1) : r_dest_width;
        if (eff_width > COL_W'(MAX_COLUMNS)) begin
            eff_width = COL_W'(MAX_COLUMNS);
        end
        h_clamp   = (r_image_height > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : r_image_height;
        pairs_raw = PAIR_W'(({1'b0, h_clamp} + (ROW_W+1)'(1)) >> 1);
        eff_pairs = (pairs_raw == '0) ? PAIR_W'(1) : pairs_raw;
    end

    // Blend the three channels
    always_comb begin
        w1      = r_phase[FRAC_BITS-1:0];
        w0      = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, w1};
        s_red   = (FRAC_BITS+6)'(i_left_pixel[15:11] * w0)
                + (FRAC_BITS+6)'(i_right_pixel[15:11] * {1'b0, w1});
        s_green = (FRAC_BITS+7)'(i_left_pixel[10:5] * w0)
                + (FRAC_BITS+7)'(i_right_pixel[10:5] * {1'b0, w1});
        s_blue  = (FRAC_BITS+6)'(i_left_pixel[4:0] * w0)
                + (FRAC_BITS+6)'(i_right_pixel[4:0] * {1'b0, w1});
        pix     = {s_red[FRAC_BITS +: 5], s_green[FRAC_BITS +: 6], s_blue[FRAC_BITS +: 5]};
    end

    // Advance row pair, column and phase
    always_comb begin
        frame_start = (r_col == '0) && (r_pair == '0) && ~r_even;
        step_use    = frame_start ? PHASE_W'(r_div_q) : r_phase_step;
        cur_row     = {r_pair, ~r_even};
        last_col    = ({1'b0, r_col} + (COL_W+1)'(1)) >= {1'b0, eff_width};
        last_pair   = ({1'b0, r_pair} + (PAIR_W+1)'(1)) >= {1'b0, eff_pairs};
        n_even      = ~r_even;
        n_pair      = r_pair;
        n_col       = r_col;
        n_phase     = r_phase;
        frame_last  = 1'b0;
        if (r_even) begin
            if (!last_pair) begin
                n_pair = r_pair + PAIR_W'(1);
            end else begin
                n_pair = '0;
                if (!last_col) begin
                    n_col   = r_col + COL_W'(1);
                    n_phase = r_phase + step_use;
                end else begin
                    n_col      = '0;
                    n_phase    = '0;
                    frame_last = 1'b1;
                end
            end
        end
        nxt_row = {n_pair, ~n_even};
        addr    = ADDR_W'(nxt_row * r_source_pitch)
                + ADDR_W'(n_phase[PHASE_W-1:FRAC_BITS]);
    end

    // Divider step
    always_comb begin
        div_sh  = {r_div_rem, r_div_q[NUM_W-1]};
        div_bit = div_sh >= {1'b0, r_div_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_width   <= COL_W'(320);
            r_source_width <= COL_W'(256);
            r_image_height <= ROW_W'(240);
            r_source_pitch <= PITCH_W'(256);
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                CFG_DEST_WIDTH:   r_dest_width   <= i_cfg_data[COL_W-1:0];
                CFG_SOURCE_WIDTH: r_source_width <= i_cfg_data[COL_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[ROW_W-1:0];
                CFG_SOURCE_PITCH: r_source_pitch <= i_cfg_data[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    // Restart the divider after reset and after every register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_load <= 1'b1;
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else if (cfg_xfer) begin
            r_div_load <= 1'b1;
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else if (r_div_load) begin
            r_div_load <= 1'b0;
            r_div_busy <= 1'b1;
            r_div_cnt  <= DCNT_W'(NUM_W);
        end else if (r_div_busy) begin
            r_div_cnt  <= r_div_cnt - DCNT_W'(1);
            r_div_busy <= (r_div_cnt != DCNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_div_load) begin
            r_div_q   <= {r_source_width, {FRAC_BITS{1'b0}}};
            r_div_rem <= '0;
            r_div_den <= eff_width;
        end else if (r_div_busy) begin
            r_div_q   <= {r_div_q[NUM_W-2:0], div_bit};
            r_div_rem <= div_bit ? COL_W'(div_sh - {1'b0, r_div_den}) : div_sh[COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_col   <= '0;
            r_pair  <= '0;
            r_even  <= 1'b0;
        end else if (in_xfer) begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_pair  <= n_pair;
            r_even  <= n_even;
        end
    end

    // Hold the step latched at frame start
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_phase_step <= step_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pix   <= pix;
            r_ocol  <= r_col;
            r_orow  <= cur_row;
            r_oaddr <= addr;
            r_olast <= frame_last;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_pixel_out          = r_pix;
    assign o_dest_column        = r_ocol;
    assign o_dest_row           = r_orow;
    assign o_next_fetch_address = r_oaddr;
    assign o_frame_last         = r_olast;

`ifndef ASSERT_OFF
    a_no_xfer_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> (!r_div_busy && !r_div_load))
        else $error("pixel transfer taken while phase step not ready");

    a_frame_start_phase_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col == '0 && r_pair == '0 && !r_even) |-> (r_phase == '0))
        else $error("phase not zero at frame start");

    a_last_on_even_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_last) |-> (o_dest_row[0] == 1'b0))
        else $error("frame end flagged on an odd row");

    a_div_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> (r_div_cnt != '0))
        else $error("divider busy with zero step count");

    a_frame_end_resets_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && frame_last) |=> (r_col == '0 && r_pair == '0 && !r_even))
        else $error("scan counters not cleared after frame end");
`endif

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for rgb565_hscale_transpose: a directed table, then random frames, with every
// output transfer checked against the table entry or a local model of the scaler. Depends on rgbhst_pkg.

module testbench;
    import rgbhst_pkg::*;

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          RANDOM_PAIRS = 1400;
    localparam int          MAX_WAIT     = 14;
    localparam int          BATCH_CAP    = 96;
    localparam int          N_DIRECTED   = 31;
    localparam logic [15:0] RED_MASK     = 16'hF800;
    localparam logic [15:0] GREEN_MASK   = 16'h07E0;
    localparam logic [15:0] BLUE_MASK    = 16'h001F;
    // index that maps to no register; the block must ignore writes to it
    localparam t_cfg_idx    CFG_UNMAPPED = t_cfg_idx'(7);

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] fetch_addr;
        logic              last;
    } t_scaled_px;

    typedef enum logic { ROW_PAIR, ROW_REG } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
        logic [PIX_W-1:0]      left;
        logic [PIX_W-1:0]      right;
        logic                  known;
        t_scaled_px            want;
    } t_drive_row;

    localparam t_scaled_px NOT_TYPED = '0;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_ready;
    logic [PIX_W-1:0]      i_left_pixel  = '0;
    logic [PIX_W-1:0]      i_right_pixel = '0;
    logic                  o_out_valid;
    logic                  i_out_ready   = 1'b0;
    logic [PIX_W-1:0]      o_pixel_out;
    logic [COL_W-1:0]      o_dest_column;
    logic [ROW_W-1:0]      o_dest_row;
    logic [ADDR_W-1:0]     o_next_fetch_address;
    logic                  o_frame_last;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    rgb565_hscale_transpose DUT (.*);

    // Model state: registers hold their reset values
    logic [COL_W-1:0]   dest_w     = COL_W'(320);
    logic [COL_W-1:0]   src_w      = COL_W'(256);
    logic [ROW_W-1:0]   height     = ROW_W'(240);
    logic [PITCH_W-1:0] pitch      = PITCH_W'(256);
    logic [PHASE_W-1:0] phase      = '0;
    logic [PHASE_W-1:0] step       = '0;
    logic [COL_W-1:0]   col_cnt    = '0;
    logic [PAIR_W-1:0]  pair_cnt   = '0;
    logic               second_row = 1'b0;

    t_scaled_px  scaled_q [$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left  = 0;
    bit          quiet_mode  = 1'b0;

    t_drive_row directed_plan [N_DIRECTED] = '{
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'hFFFF, 16'h0000, 1'b1,
          '{16'hFFFF, 10'd0, 9'd1, 20'd0, 1'b0}},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'h0000, 16'hFFFF, 1'b1,
          '{16'h0000, 10'd0, 9'd0, 20'd768, 1'b0}},
        // shrink the frame while it is under way
        '{ROW_REG, CFG_DEST_WIDTH, 10'd2, 16'h0000, 16'h0000, 1'b0, NOT_TYPED},
        '{ROW_REG, CFG_SOURCE_WIDTH, 10'd1023, 16'h0000, 16'h0000, 1'b0, NOT_TYPED},
        '{ROW_REG, CFG_IMAGE_HEIGHT, 10'd1, 16'h0000, 16'h0000, 1'b0, NOT_TYPED},
        '{ROW_REG, CFG_SOURCE_PITCH, 10'd1023, 16'h0000, 16'h0000, 1'b0, NOT_TYPED},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'hA5A5, 16'h5A5A, 1'b1,
          '{16'hA5A5, 10'd0, 9'd3, 20'd2046, 1'b0}},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'h1234, 16'hEDCB, 1'b1,
          '{16'h1234, 10'd0, 9'd2, 20'd1023, 1'b0}},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'hF800, 16'h07E0, 1'b0, NOT_TYPED},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'h07E0, 16'hF800, 1'b0, NOT_TYPED},
        // new frame: step is half a pixel plus 511 whole columns
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'h001F, 16'hFFE0, 1'b1,
          '{16'h001F, 10'd0, 9'd1, 20'd0, 1'b0}},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'h8410, 16'h7BEF, 1'b1,
          '{16'h8410, 10'd0, 9'd0, 20'd1534, 1'b0}},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'hFFFF, 16'h0000, 1'b1,
          '{16'h7BEF, 10'd1, 9'd1, 20'd511, 1'b0}},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'h0000, 16'hFFFF, 1'b1,
          '{16'h7BEF, 10'd1, 9'd0, 20'd1023, 1'b1}},
        // zero width and zero height both collapse to a single pair
        '{ROW_REG, CFG_DEST_WIDTH, 10'd0, 16'h0000, 16'h0000, 1'b0, NOT_TYPED},
        '{ROW_REG, CFG_SOURCE_WIDTH, 10'd5, 16'h0000, 16'h0000, 1'b0, NOT_TYPED},
        '{ROW_REG, CFG_IMAGE_HEIGHT, 10'd0, 16'h0000, 16'h0000, 1'b0, NOT_TYPED},
        '{ROW_REG, CFG_SOURCE_PITCH, 10'd1, 16'h0000, 16'h0000, 1'b0, NOT_TYPED},
        '{ROW_REG, CFG_UNMAPPED, 10'h3FF, 16'h0000, 16'h0000, 1'b0, NOT_TYPED},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'h07E0, 16'hF81F, 1'b1,
          '{16'h07E0, 10'd0, 9'd1, 20'd0, 1'b0}},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'hF81F, 16'h07E0, 1'b1,
          '{16'hF81F, 10'd0, 9'd0, 20'd1, 1'b1}},
        // latch the largest step with one column, then widen mid-frame to wrap the phase
        '{ROW_REG, CFG_DEST_WIDTH, 10'd1, 16'h0000, 16'h0000, 1'b0, NOT_TYPED},
        '{ROW_REG, CFG_SOURCE_WIDTH, 10'd1023, 16'h0000, 16'h0000, 1'b0, NOT_TYPED},
        '{ROW_REG, CFG_IMAGE_HEIGHT, 10'd1, 16'h0000, 16'h0000, 1'b0, NOT_TYPED},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'h5555, 16'hAAAA, 1'b1,
          '{16'h5555, 10'd0, 9'd1, 20'd0, 1'b0}},
        '{ROW_REG, CFG_DEST_WIDTH, 10'd1023, 16'h0000, 16'h0000, 1'b0, NOT_TYPED},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'hAAAA, 16'h5555, 1'b0, NOT_TYPED},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'hFFFF, 16'h0000, 1'b0, NOT_TYPED},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'h0000, 16'hFFFF, 1'b0, NOT_TYPED},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'hC3C3, 16'h3C3C, 1'b0, NOT_TYPED},
        '{ROW_PAIR, CFG_UNMAPPED, 10'd0, 16'h7BEF, 16'h8410, 1'b0, NOT_TYPED}
    };

    function automatic int unsigned columns_used();
        int unsigned w;
        w = (dest_w == 0) ? 1 : 32'(dest_w);
        return (w > MAX_COLUMNS) ? MAX_COLUMNS : w;
    endfunction

    function automatic int unsigned pairs_used();
        int unsigned h, p;
        h = (32'(height) > MAX_ROWS) ? MAX_ROWS : 32'(height);
        p = (h + 1) / 2;
        return (p == 0) ? 1 : p;
    endfunction

    function automatic logic [ROW_W-1:0] current_row();
        return {pair_cnt, ~second_row};
    endfunction

    function automatic logic [PIX_W-1:0] mix_channel(logic [PIX_W-1:0] a, b, mask,
                                                     longint unsigned w0, w1);
        longint unsigned acc;
        acc = 64'(a & mask) * w0 + 64'(b & mask) * w1;
        return PIX_W'(acc >> FRAC_BITS) & mask;
    endfunction

    // Blend one pixel pair and advance the column/row walk
    function automatic t_scaled_px scale_pair(logic [PIX_W-1:0] left, right);
        t_scaled_px      res;
        longint unsigned w0, w1;
        logic            end_col, end_pair;
        if (col_cnt == 0 && pair_cnt == 0 && !second_row)
            step = PHASE_W'((64'(src_w) << FRAC_BITS) / columns_used());
        w1 = 64'(phase[FRAC_BITS-1:0]);
        w0 = (64'd1 << FRAC_BITS) - w1;
        res.pixel = mix_channel(left, right, RED_MASK, w0, w1)
                  | mix_channel(left, right, GREEN_MASK, w0, w1)
                  | mix_channel(left, right, BLUE_MASK, w0, w1);
        res.column = col_cnt;
        res.row    = current_row();
        res.last   = 1'b0;
        end_col  = 32'(col_cnt) + 1 >= columns_used();
        end_pair = 32'(pair_cnt) + 1 >= pairs_used();
        if (!second_row) begin
            second_row = 1'b1;
        end else begin
            second_row = 1'b0;
            if (!end_pair) begin
                pair_cnt = pair_cnt + 1'b1;
            end else begin
                pair_cnt = '0;
                if (!end_col) begin
                    col_cnt = col_cnt + 1'b1;
                    phase   = phase + step;
                end else begin
                    res.last = 1'b1;
                    col_cnt  = '0;
                    phase    = '0;
                end
            end
        end
        res.fetch_addr = ADDR_W'(64'(current_row()) * 64'(pitch) + 64'(phase >> FRAC_BITS));
        return res;
    endfunction

    function automatic void apply_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DEST_WIDTH:   dest_w = data;
            CFG_SOURCE_WIDTH: src_w  = data;
            CFG_IMAGE_HEIGHT: height = data[ROW_W-1:0];
            CFG_SOURCE_PITCH: pitch  = data;
            default: ;
        endcase
    endfunction

    function automatic int unsigned draw_wait();
        return quiet_mode ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(t_cfg_idx idx);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        case (idx)
            CFG_DEST_WIDTH:
                return (pick == 2) ? CFG_DATA_W'($urandom_range(1, MAX_COLUMNS))
                                   : CFG_DATA_W'($urandom_range(1, 6));
            CFG_IMAGE_HEIGHT:
                // bit 9 lies above the register and must be dropped
                return (pick == 2) ? CFG_DATA_W'($urandom_range(500, 1023))
                                   : CFG_DATA_W'($urandom_range(1, 12)
                                                 + ($urandom_range(0, 1) << 9));
            default:
                return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic void check_field(string name, logic [ADDR_W-1:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_pair(input logic [PIX_W-1:0] left, right, input logic known,
                             input t_scaled_px want);
        int unsigned gap;
        t_scaled_px  calc;
        gap = draw_wait();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_left_pixel  <= left;
        i_right_pixel <= right;
        calc = scale_pair(left, right);
        scaled_q.push_back(known ? want : calc);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
    endtask

    // Hold the input side until every pending result has been transferred
    task automatic drain();
        i_in_valid <= 1'b0;
        while (scaled_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rgb565_hscale_transpose: mismatch");
            $finish;
        end
    end

    // Output side: stall a random number of cycles after each transfer
    always @(posedge i_clk) begin : pace_results
        int unsigned hold;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (i_out_ready) begin
            if (o_out_valid) begin
                hold = draw_wait();
                if (hold != 0) begin
                    i_out_ready <= 1'b0;
                    stall_left  <= hold - 1;
                end
            end
        end else if (stall_left == 0) begin
            i_out_ready <= 1'b1;
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_scaled_px want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (scaled_q.size() == 0) begin
                $error("pixel_out %0h transferred with nothing expected", o_pixel_out);
                fail_count++;
            end else begin
                want = scaled_q.pop_front();
                check_field("pixel_out", ADDR_W'(want.pixel), ADDR_W'(o_pixel_out));
                check_field("dest_column", ADDR_W'(want.column), ADDR_W'(o_dest_column));
                check_field("dest_row", ADDR_W'(want.row), ADDR_W'(o_dest_row));
                check_field("next_fetch_address", want.fetch_addr, o_next_fetch_address);
                check_field("frame_last", ADDR_W'(want.last), ADDR_W'(o_frame_last));
            end
        end
    end

    initial begin : stimulus
        logic        reg_open;
        int unsigned random_done;
        int unsigned frame_len;
        int unsigned batch;
        reg_open    = 1'b0;
        random_done = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[k]) begin
            if (directed_plan[k].kind == ROW_REG) begin
                if (!reg_open) begin
                    drain();
                    reg_open = 1'b1;
                end
                write_reg(directed_plan[k].idx, directed_plan[k].data);
            end else begin
                if (reg_open) begin
                    i_cfg_valid <= 1'b0;
                    reg_open = 1'b0;
                end
                send_pair(directed_plan[k].left, directed_plan[k].right,
                          directed_plan[k].known, directed_plan[k].want);
            end
        end

        while (random_done < RANDOM_PAIRS) begin
            drain();
            quiet_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1)) write_reg(CFG_DEST_WIDTH, pick_reg_value(CFG_DEST_WIDTH));
            if ($urandom_range(0, 1))
                write_reg(CFG_SOURCE_WIDTH, pick_reg_value(CFG_SOURCE_WIDTH));
            if ($urandom_range(0, 1))
                write_reg(CFG_IMAGE_HEIGHT, pick_reg_value(CFG_IMAGE_HEIGHT));
            if ($urandom_range(0, 1))
                write_reg(CFG_SOURCE_PITCH, pick_reg_value(CFG_SOURCE_PITCH));
            if ($urandom_range(0, 19) == 0) write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
            i_cfg_valid <= 1'b0;

            // run a whole frame's worth of pairs where frames are short, else a partial one; at times a random batch
            frame_len = 2 * columns_used() * pairs_used();
            batch = (frame_len <= BATCH_CAP) ? frame_len : $urandom_range(1, BATCH_CAP);
            if ($urandom_range(0, 4) == 0) batch = $urandom_range(1, BATCH_CAP);
            repeat (batch) begin
                send_pair(pick_pixel(), pick_pixel(), 1'b0, NOT_TYPED);
                random_done++;
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("rgb565_hscale_transpose: match");
        else
            $display("rgb565_hscale_transpose: mismatch");
        $finish;
    end

endmodule
